// ===== design/ldcm_pkg.sv =====
// Shared types, constants and a saturating add helper for the lens distortion coordinate map.
// No dependencies; every other design file imports this package.
package ldcm_pkg;

  // Intermediate values: signed, 32 fraction bits, held within +/- 2^61.
  typedef logic signed [62:0] val_t;

  localparam val_t VAL_LIM  = 63'sd2305843009213693952;
  localparam val_t VAL_ONE  = 63'sd4294967296;
  localparam val_t VAL_HALF = 63'sd2147483648;

  // Register stages between the input beat and the output register.
  localparam int STAGES = 30;

  localparam int PIX_W     = 16;
  localparam int REG_COUNT = 7;
  localparam int CFG_IDX_W = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_INVERSE_FOCAL     = 3'd0;
  localparam cfg_idx_t REG_PRINCIPAL_POINT   = 3'd1;
  localparam cfg_idx_t REG_RADIAL_COEFFS     = 3'd2;
  localparam cfg_idx_t REG_TANGENTIAL_COEFFS = 3'd3;
  localparam cfg_idx_t REG_SOURCE_FOCAL      = 3'd4;
  localparam cfg_idx_t REG_SOURCE_CENTER     = 3'd5;
  localparam cfg_idx_t REG_RESAMPLE_RATIO    = 3'd6;

  // Sum of two in-range values, clamped back to +/- 2^61.
  function automatic val_t sat_add(val_t a, val_t b);
    logic signed [63:0] s;
    s = 64'(a) + 64'(b);
    if (s > 64'(VAL_LIM)) begin
      sat_add = VAL_LIM;
    end else if (s < -64'(VAL_LIM)) begin
      sat_add = -VAL_LIM;
    end else begin
      sat_add = s[62:0];
    end
  endfunction

endpackage

// ===== design/lens_distortion_coordinate_map_core.sv =====
// Top level of the lens distortion coordinate map: stream ports, configuration
// registers and the fully pipelined datapath. Depends on ldcm_pkg and ldcm_smul.

// The block takes one pixel coordinate beat per clock cycle while s_axis_tready is high,
// that is while the skid register is empty, and returns one source coordinate beat for
// each, in order, once the output side is ready. The datapath is sixteen four-stage
// multipliers in six dependent rounds plus the saturating adds between them and the
// final rounding. An output register and a one-beat skid register sit after the
// pipeline, so new beats keep entering while a finished beat waits; s_axis_tready drops
// only once both are full. With all four distortion coefficients zero the result is the
// plain rescale (p + 0.5) * ratio - 0.5; otherwise the Brown-Conrady model is applied.
// Configuration must only be written while no beats are in flight.
module lens_distortion_coordinate_map_core #(
  parameter int COORD_BITS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,   // pixel_x [15:0], pixel_y [31:16]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [63:0]        m_axis_tdata,   // src_col [31:0], src_row [63:32]
  input  logic               cfg_we_i,
  input  ldcm_pkg::cfg_idx_t cfg_index_i,
  input  logic [63:0]        cfg_wdata_i
);
  import ldcm_pkg::*;

  localparam int                 OutShift = 32 - FRACTION_BITS;
  localparam logic signed [63:0] OutRound = 64'sd1 <<< (OutShift - 1);
  localparam int                 RsW      = COORD_BITS + 33;

  // Configuration
  logic [63:0] cfg_q [REG_COUNT];

  logic [31:0]        ifx, ify, cx, cy, sfx, sfy, scx, scy, rlo, rhi;
  logic signed [31:0] k1, k2, p1, p2;
  logic               coef_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_INVERSE_FOCAL, REG_PRINCIPAL_POINT, REG_RADIAL_COEFFS, REG_TANGENTIAL_COEFFS,
        REG_SOURCE_FOCAL, REG_SOURCE_CENTER, REG_RESAMPLE_RATIO: begin
          cfg_q[cfg_index_i] <= cfg_wdata_i;
        end
        default: ;
      endcase
    end
  end

  assign ifx = cfg_q[REG_INVERSE_FOCAL][31:0];
  assign ify = cfg_q[REG_INVERSE_FOCAL][63:32];
  assign cx  = cfg_q[REG_PRINCIPAL_POINT][31:0];
  assign cy  = cfg_q[REG_PRINCIPAL_POINT][63:32];
  assign k1  = cfg_q[REG_RADIAL_COEFFS][31:0];
  assign k2  = cfg_q[REG_RADIAL_COEFFS][63:32];
  assign p1  = cfg_q[REG_TANGENTIAL_COEFFS][31:0];
  assign p2  = cfg_q[REG_TANGENTIAL_COEFFS][63:32];
  assign sfx = cfg_q[REG_SOURCE_FOCAL][31:0];
  assign sfy = cfg_q[REG_SOURCE_FOCAL][63:32];
  assign scx = cfg_q[REG_SOURCE_CENTER][31:0];
  assign scy = cfg_q[REG_SOURCE_CENTER][63:32];
  assign rlo = cfg_q[REG_RESAMPLE_RATIO][31:0];
  assign rhi = cfg_q[REG_RESAMPLE_RATIO][63:32];

  assign coef_zero = (cfg_q[REG_RADIAL_COEFFS] == '0) && (cfg_q[REG_TANGENTIAL_COEFFS] == '0);

  // Pipeline control: every stage moves together unless the skid register is occupied.
  logic              en;
  logic [STAGES:1]   v_q;
  logic              out_v_q, skid_v_q;
  logic              take;
  logic [63:0]       out_q, skid_q, res_d;

  assign en            = !skid_v_q;
  assign take          = out_v_q && m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  // Datapath signals, named by the stage whose register holds them.
  logic [COORD_BITS-1:0] px, py;
  logic signed [33:0]    dx_q, dy_q;
  logic [COORD_BITS:0]   pqx_q [1:28];
  logic [COORD_BITS:0]   pqy_q [1:28];
  val_t xn_m, yn_m, xx_m, yy_m, xy_m, p1xy_m, p2xy_m, k1r2_m, k2r2_m;
  val_t pa_m, pb_m, k2r2r2_m, xnr_m, ynr_m, sxm_m, sym_m;
  val_t r2_q, xx2_q, yy2_q, ax_q, ay_q, radial_q;
  val_t xd1_q, yd1_q, xd_q, yd_q, sx_q, sy_q, sxr_q, syr_q;
  val_t xnd_q  [6:19];
  val_t ynd_q  [6:19];
  val_t r2d_q  [11:14];
  val_t t2x_q  [14:23];
  val_t t2y_q  [14:24];
  val_t rad1_q [15:18];
  val_t pad_q  [16:24];
  val_t pbd_q  [16:23];
  logic [RsW-1:0] rsx_q, rsy_q;

  assign px = s_axis_tdata[COORD_BITS-1:0];
  assign py = s_axis_tdata[PIX_W +: COORD_BITS];

  ldcm_smul #(.SH(8))  u_xn (.clk_i, .en_i(en), .a_i(val_t'(dx_q)), .b_i(val_t'(ifx)), .p_o(xn_m));
  ldcm_smul #(.SH(8))  u_yn (.clk_i, .en_i(en), .a_i(val_t'(dy_q)), .b_i(val_t'(ify)), .p_o(yn_m));
  ldcm_smul #(.SH(32)) u_xx (.clk_i, .en_i(en), .a_i(xn_m), .b_i(xn_m), .p_o(xx_m));
  ldcm_smul #(.SH(32)) u_yy (.clk_i, .en_i(en), .a_i(yn_m), .b_i(yn_m), .p_o(yy_m));
  ldcm_smul #(.SH(32)) u_xy (.clk_i, .en_i(en), .a_i(xn_m), .b_i(yn_m), .p_o(xy_m));
  ldcm_smul #(.SH(28)) u_p1xy (.clk_i, .en_i(en), .a_i(val_t'(p1)), .b_i(xy_m), .p_o(p1xy_m));
  ldcm_smul #(.SH(28)) u_p2xy (.clk_i, .en_i(en), .a_i(val_t'(p2)), .b_i(xy_m), .p_o(p2xy_m));
  ldcm_smul #(.SH(28)) u_k1r2 (.clk_i, .en_i(en), .a_i(val_t'(k1)), .b_i(r2_q), .p_o(k1r2_m));
  ldcm_smul #(.SH(28)) u_k2r2 (.clk_i, .en_i(en), .a_i(val_t'(k2)), .b_i(r2_q), .p_o(k2r2_m));
  ldcm_smul #(.SH(28)) u_pa (.clk_i, .en_i(en), .a_i(val_t'(p2)), .b_i(ax_q), .p_o(pa_m));
  ldcm_smul #(.SH(28)) u_pb (.clk_i, .en_i(en), .a_i(val_t'(p1)), .b_i(ay_q), .p_o(pb_m));
  ldcm_smul #(.SH(32)) u_k2r2r2 (
    .clk_i, .en_i(en), .a_i(k2r2_m), .b_i(r2d_q[14]), .p_o(k2r2r2_m)
  );
  ldcm_smul #(.SH(32)) u_xnr (.clk_i, .en_i(en), .a_i(xnd_q[19]), .b_i(radial_q), .p_o(xnr_m));
  ldcm_smul #(.SH(32)) u_ynr (.clk_i, .en_i(en), .a_i(ynd_q[19]), .b_i(radial_q), .p_o(ynr_m));
  ldcm_smul #(.SH(16)) u_sx (.clk_i, .en_i(en), .a_i(val_t'(sfx)), .b_i(xd_q), .p_o(sxm_m));
  ldcm_smul #(.SH(16)) u_sy (.clk_i, .en_i(en), .a_i(val_t'(sfy)), .b_i(yd_q), .p_o(sym_m));

  always_ff @(posedge clk_i) begin
    if (en) begin
      // Offset from the principal point, and 2p+1 for the rescale path.
      dx_q     <= $signed({2'b00, 32'({px, 16'b0})}) - $signed({2'b00, cx});
      dy_q     <= $signed({2'b00, 32'({py, 16'b0})}) - $signed({2'b00, cy});
      pqx_q[1] <= {px, 1'b1};
      pqy_q[1] <= {py, 1'b1};
      for (int i = 2; i <= 28; i++) begin
        pqx_q[i] <= pqx_q[i-1];
        pqy_q[i] <= pqy_q[i-1];
      end

      xnd_q[6] <= xn_m;
      ynd_q[6] <= yn_m;
      for (int i = 7; i <= 19; i++) begin
        xnd_q[i] <= xnd_q[i-1];
        ynd_q[i] <= ynd_q[i-1];
      end

      r2_q     <= sat_add(xx_m, yy_m);
      xx2_q    <= sat_add(xx_m, xx_m);
      yy2_q    <= sat_add(yy_m, yy_m);
      r2d_q[11] <= r2_q;
      for (int i = 12; i <= 14; i++) begin
        r2d_q[i] <= r2d_q[i-1];
      end

      ax_q     <= sat_add(r2_q, xx2_q);
      ay_q     <= sat_add(r2_q, yy2_q);

      t2x_q[14] <= sat_add(p1xy_m, p1xy_m);
      t2y_q[14] <= sat_add(p2xy_m, p2xy_m);
      for (int i = 15; i <= 23; i++) begin
        t2x_q[i] <= t2x_q[i-1];
      end
      for (int i = 15; i <= 24; i++) begin
        t2y_q[i] <= t2y_q[i-1];
      end

      rad1_q[15] <= sat_add(VAL_ONE, k1r2_m);
      for (int i = 16; i <= 18; i++) begin
        rad1_q[i] <= rad1_q[i-1];
      end
      radial_q <= sat_add(rad1_q[18], k2r2r2_m);

      pad_q[16] <= pa_m;
      pbd_q[16] <= pb_m;
      for (int i = 17; i <= 24; i++) begin
        pad_q[i] <= pad_q[i-1];
      end
      for (int i = 17; i <= 23; i++) begin
        pbd_q[i] <= pbd_q[i-1];
      end

      xd1_q <= sat_add(xnr_m, t2x_q[23]);
      yd1_q <= sat_add(ynr_m, pbd_q[23]);
      xd_q  <= sat_add(xd1_q, pad_q[24]);
      yd_q  <= sat_add(yd1_q, t2y_q[24]);

      sx_q  <= sat_add(sxm_m, val_t'({scx, 16'b0}));
      sy_q  <= sat_add(sym_m, val_t'({scy, 16'b0}));

      // Rescale path: (2p+1)*ratio is Q.25, seven more bits reach Q.32.
      rsx_q <= pqx_q[28] * rlo;
      rsy_q <= pqy_q[28] * rhi;
      sxr_q <= val_t'({rsx_q, 7'b0}) - VAL_HALF;
      syr_q <= val_t'({rsy_q, 7'b0}) - VAL_HALF;
    end
  end

  // Round half up to FRACTION_BITS and saturate to the 32-bit signed range.
  function automatic logic [31:0] to_out(val_t v);
    logic signed [63:0] r;
    r = (64'(v) + OutRound) >>> OutShift;
    if (r > 64'sd2147483647) begin
      to_out = 32'h7fff_ffff;
    end else if (r < -64'sd2147483648) begin
      to_out = 32'h8000_0000;
    end else begin
      to_out = r[31:0];
    end
  endfunction

  always_comb begin
    if (coef_zero) begin
      res_d = {to_out(syr_q), to_out(sxr_q)};
    end else begin
      res_d = {to_out(sy_q), to_out(sx_q)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q      <= '0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (en) begin
        v_q <= {v_q[STAGES-1:1], s_axis_tvalid};
      end
      if (skid_v_q) begin
        if (take) begin
          skid_v_q <= 1'b0;
        end
      end else if (v_q[STAGES]) begin
        if (out_v_q && !take) begin
          skid_v_q <= 1'b1;
        end else begin
          out_v_q <= 1'b1;
        end
      end else if (take) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (v_q[STAGES]) begin
      if (out_v_q && !take) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

endmodule

// ===== design/ldcm_smul.sv =====
// Four-stage signed fixed-point multiplier: (a*b) >> SH, magnitude rounded half up,
// saturated to +/- 2^61. Built from four 32x32 partial products. Depends on ldcm_pkg.
module ldcm_smul #(
  parameter int SH = 32
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  ldcm_pkg::val_t a_i,
  input  ldcm_pkg::val_t b_i,
  output ldcm_pkg::val_t p_o
);
  import ldcm_pkg::*;

  typedef logic [62:0] mag_t;

  localparam logic [127:0] Round = 128'd1 << (SH - 1);

  logic         neg1_q, neg2_q, neg3_q;
  mag_t         ua_q, ub_q;
  logic [63:0]  p00_q;
  logic [62:0]  p01_q, p10_q;
  logic [61:0]  p11_q;
  logic [127:0] prod_q;
  val_t         p_q;

  logic [63:0]  mid;
  logic [127:0] prod_d;
  logic [127:0] quot;
  logic [61:0]  mag;
  val_t         p_d;

  always_comb begin
    mid    = 64'(p01_q) + 64'(p10_q);
    prod_d = {2'b00, p11_q, p00_q} + {32'b0, mid, 32'b0} + Round;
    quot   = prod_q >> SH;
    if (quot > 128'(VAL_LIM)) begin
      mag = VAL_LIM[61:0];
    end else begin
      mag = quot[61:0];
    end
    p_d = neg3_q ? -val_t'({1'b0, mag}) : val_t'({1'b0, mag});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= a_i[62] ^ b_i[62];
      ua_q   <= a_i[62] ? mag_t'(-a_i) : mag_t'(a_i);
      ub_q   <= b_i[62] ? mag_t'(-b_i) : mag_t'(b_i);

      neg2_q <= neg1_q;
      p00_q  <= ua_q[31:0] * ub_q[31:0];
      p01_q  <= ua_q[31:0] * ub_q[62:32];
      p10_q  <= ua_q[62:32] * ub_q[31:0];
      p11_q  <= ua_q[62:32] * ub_q[62:32];

      neg3_q <= neg2_q;
      prod_q <= prod_d;

      p_q    <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ===== design/ldcm_checker.sv =====
// Port-level checker for the lens distortion coordinate map, bound to the top level.
// Depends on ldcm_pkg for the pipeline depth.
module ldcm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);
  import ldcm_pkg::*;

  localparam int CntW = $clog2(STAGES + 3);

  logic [CntW-1:0] cnt_q;
  logic            in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Beats accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + CntW'(in_acc) - CntW'(out_acc);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat withdrawn while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_q != '0)
    else $error("output beat offered with no input beat outstanding");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> cnt_q <= CntW'(STAGES + 1))
    else $error("input beat accepted beyond pipeline capacity");

endmodule

bind lens_distortion_coordinate_map_core ldcm_checker u_ldcm_checker (.*);

// ===== verif/ldcm_coord_checker.sv =====
// Checker for the lens distortion coordinate map: watches the pixel, source and register
// write channels, predicts each source coordinate and compares it with what the block returns.
// Depends on ldcm_pkg for the register index type and names.
`timescale 1ns / 1ps

module ldcm_coord_checker #(
  parameter int COORD_BITS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pix_valid_i,
  input  logic               pix_ready_i,
  input  logic [31:0]        pix_data_i,   // pixel_x [15:0], pixel_y [31:16]
  input  logic               src_valid_i,
  input  logic               src_ready_i,
  input  logic [63:0]        src_data_i,   // src_col [31:0], src_row [63:32]
  input  logic               cfg_we_i,
  input  ldcm_pkg::cfg_idx_t cfg_index_i,
  input  logic [63:0]        cfg_wdata_i,
  output int                 mismatches_o,
  output int                 pending_o,
  output int                 checked_o
);

  typedef struct packed {
    logic [15:0] pixel_y;
    logic [15:0] pixel_x;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] src_row;
    logic signed [31:0] src_col;
  } src_coord_t;

  localparam longint       SAT_BOUND  = 64'sh2000_0000_0000_0000;
  localparam logic [127:0] MAG_BOUND  = 128'h2000_0000_0000_0000;
  localparam longint       ONE_Q32    = 64'sh1_0000_0000;
  localparam longint       HALF_Q32   = 64'sh8000_0000;
  localparam int           FRAC_SHIFT = 32 - FRACTION_BITS;
  localparam logic [15:0]  COORD_MASK = 16'((32'd1 << COORD_BITS) - 1);

  logic [63:0] inv_focal_q, principal_q, radial_q, tangential_q;
  logic [63:0] src_focal_q, src_center_q, ratio_q;

  src_coord_t pending_coords[$];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_focal_q  <= '0;
      principal_q  <= '0;
      radial_q     <= '0;
      tangential_q <= '0;
      src_focal_q  <= '0;
      src_center_q <= '0;
      ratio_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ldcm_pkg::REG_INVERSE_FOCAL:     inv_focal_q  <= cfg_wdata_i;
        ldcm_pkg::REG_PRINCIPAL_POINT:   principal_q  <= cfg_wdata_i;
        ldcm_pkg::REG_RADIAL_COEFFS:     radial_q     <= cfg_wdata_i;
        ldcm_pkg::REG_TANGENTIAL_COEFFS: tangential_q <= cfg_wdata_i;
        ldcm_pkg::REG_SOURCE_FOCAL:      src_focal_q  <= cfg_wdata_i;
        ldcm_pkg::REG_SOURCE_CENTER:     src_center_q <= cfg_wdata_i;
        ldcm_pkg::REG_RESAMPLE_RATIO:    ratio_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  function automatic longint clip(longint v);
    if (v > SAT_BOUND) return SAT_BOUND;
    if (v < -SAT_BOUND) return -SAT_BOUND;
    return v;
  endfunction

  function automatic longint sum_sat(longint a, longint b);
    return clip(clip(a) + clip(b));
  endfunction

  // Product of magnitudes, rounded half up and shifted, so ties go away from zero.
  function automatic longint mul_round(longint a, longint b, int unsigned sh);
    logic [63:0]  ma, mb;
    logic [127:0] prod;
    logic         negative;
    longint       mag;
    negative = (a < 0) != (b < 0);
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    prod = {64'd0, ma} * {64'd0, mb};
    prod = prod + (128'd1 << (sh - 1));
    prod = prod >> sh;
    if (prod > MAG_BOUND) prod = MAG_BOUND;
    mag = longint'(prod[63:0]);
    return negative ? -mag : mag;
  endfunction

  function automatic logic signed [31:0] to_coord(longint v);
    longint q;
    q = (clip(v) + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
    if (q > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (q < -64'sd2147483648) return 32'sh8000_0000;
    return q[31:0];
  endfunction

  function automatic src_coord_t map_pixel(pixel_t pix);
    longint px, py, k1, k2, p1, p2, sx, sy;
    longint dx, dy, xn, yn, xx, yy, xy, r2, radial, xd, yd, t;
    src_coord_t res;
    px = longint'(pix.pixel_x & COORD_MASK);
    py = longint'(pix.pixel_y & COORD_MASK);
    k1 = longint'(signed'(radial_q[31:0]));
    k2 = longint'(signed'(radial_q[63:32]));
    p1 = longint'(signed'(tangential_q[31:0]));
    p2 = longint'(signed'(tangential_q[63:32]));
    if (k1 == 0 && k2 == 0 && p1 == 0 && p2 == 0) begin
      // (2p + 1) * ratio carries 25 fraction bits; seven more give Q.32.
      sx = ((2 * px + 1) * longint'(ratio_q[31:0])) * 128 - HALF_Q32;
      sy = ((2 * py + 1) * longint'(ratio_q[63:32])) * 128 - HALF_Q32;
    end else begin
      dx = px * 65536 - longint'(principal_q[31:0]);
      dy = py * 65536 - longint'(principal_q[63:32]);
      xn = mul_round(dx, longint'(inv_focal_q[31:0]), 8);
      yn = mul_round(dy, longint'(inv_focal_q[63:32]), 8);
      xx = mul_round(xn, xn, 32);
      yy = mul_round(yn, yn, 32);
      xy = mul_round(xn, yn, 32);
      r2 = sum_sat(xx, yy);
      radial = sum_sat(ONE_Q32, mul_round(k1, r2, 28));
      radial = sum_sat(radial, mul_round(mul_round(k2, r2, 28), r2, 32));

      t  = mul_round(p1, xy, 28);
      xd = sum_sat(mul_round(xn, radial, 32), sum_sat(t, t));
      xd = sum_sat(xd, mul_round(p2, sum_sat(r2, sum_sat(xx, xx)), 28));

      t  = mul_round(p2, xy, 28);
      yd = sum_sat(mul_round(yn, radial, 32),
                   mul_round(p1, sum_sat(r2, sum_sat(yy, yy)), 28));
      yd = sum_sat(yd, sum_sat(t, t));

      sx = sum_sat(mul_round(longint'(src_focal_q[31:0]), xd, 16),
                   longint'(src_center_q[31:0]) * 65536);
      sy = sum_sat(mul_round(longint'(src_focal_q[63:32]), yd, 16),
                   longint'(src_center_q[63:32]) * 65536);
    end
    res.src_col = to_coord(sx);
    res.src_row = to_coord(sy);
    return res;
  endfunction

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  always @(posedge clk_i) begin
    src_coord_t got, want;
    if (rst_ni) begin
      if (src_valid_i && src_ready_i) begin
        got = src_coord_t'(src_data_i);
        if (pending_coords.size() == 0) begin
          $error("source beat with no pixel outstanding: src_col %0d, src_row %0d",
                 got.src_col, got.src_row);
          mismatches_o++;
        end else begin
          want = pending_coords.pop_front();
          checked_o++;
          if (got.src_col !== want.src_col) begin
            $error("src_col: expected %0d, got %0d", want.src_col, got.src_col);
            mismatches_o++;
          end
          if (got.src_row !== want.src_row) begin
            $error("src_row: expected %0d, got %0d", want.src_row, got.src_row);
            mismatches_o++;
          end
        end
      end
      if (pix_valid_i && pix_ready_i) begin
        pending_coords.insert(pending_coords.size(), map_pixel(pixel_t'(pix_data_i)));
      end
      pending_o = pending_coords.size();
    end
  end

endmodule

// ===== verif/tb_lens_distortion_coordinate_map_core.sv =====
// Testbench top for lens_distortion_coordinate_map_core: clock, reset, register setups,
// pixel stimulus and output back-pressure. Depends on ldcm_pkg, ldcm_coord_checker and the core.
`timescale 1ns / 1ps

module tb_lens_distortion_coordinate_map_core;

  localparam int COORD_BITS    = 16;
  localparam int FRACTION_BITS = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 12;
  localparam int PHASE_BEATS   = 120;
  localparam int HOLD_OFF      = 400;

  // The first index past the last register; writes there must change nothing.
  localparam ldcm_pkg::cfg_idx_t REG_BEYOND_LAST = ldcm_pkg::cfg_idx_t'(ldcm_pkg::REG_COUNT);

  typedef enum {SETUP_LENS, SETUP_RESCALE, SETUP_ONE_TERM, SETUP_WILD, SETUP_EXTREME}
    setup_kind_e;
  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [63:0] inverse_focal;
    logic [63:0] principal_point;
    logic [63:0] radial;
    logic [63:0] tangential;
    logic [63:0] src_focal;
    logic [63:0] src_center;
    logic [63:0] resample_ratio;
  } lens_setup_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata  = '0;   // pixel_x [15:0], pixel_y [31:16]
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [63:0]        m_axis_tdata;         // src_col [31:0], src_row [63:32]
  logic               cfg_we_i      = 1'b0;
  ldcm_pkg::cfg_idx_t cfg_index_i   = '0;
  logic [63:0]        cfg_wdata_i   = '0;

  int fail_count, pending, checked;
  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int hold_cycles     = 0;
  int pixels_sent     = 0;
  int setups_done     = 0;
  int cycle_count     = 0;

  lens_distortion_coordinate_map_core #(
    .COORD_BITS   (COORD_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  ldcm_coord_checker #(
    .COORD_BITS   (COORD_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (s_axis_tvalid),
    .pix_ready_i (s_axis_tready),
    .pix_data_i  (s_axis_tdata),
    .src_valid_i (m_axis_tvalid),
    .src_ready_i (m_axis_tready),
    .src_data_i  (m_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mismatches_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $error("run did not finish within %0d cycles", CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Output side: random stalls, or a long hold-off while hold_cycles counts down.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic set_idle(idle_mode_e mode);
    sender_idle_pct = (mode == IDLE_SENDER) ? 77 : (mode == IDLE_BOTH) ? 33 : 0;
    stall_pct       = (mode == IDLE_RECEIVER) ? 77 : (mode == IDLE_BOTH) ? 33 : 0;
  endtask

  // Returns at the edge where the beat is taken, with tvalid still high.
  task automatic send_pixel(input logic [15:0] x, input logic [15:0] y);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    pixels_sent++;
  endtask

  task automatic settle();
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(ldcm_pkg::cfg_idx_t idx, logic [63:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  task automatic apply_setup(lens_setup_t s);
    s_axis_tvalid <= 1'b0;
    settle();
    write_reg(ldcm_pkg::REG_INVERSE_FOCAL, s.inverse_focal);
    write_reg(ldcm_pkg::REG_PRINCIPAL_POINT, s.principal_point);
    write_reg(ldcm_pkg::REG_RADIAL_COEFFS, s.radial);
    write_reg(ldcm_pkg::REG_TANGENTIAL_COEFFS, s.tangential);
    write_reg(ldcm_pkg::REG_SOURCE_FOCAL, s.src_focal);
    write_reg(ldcm_pkg::REG_SOURCE_CENTER, s.src_center);
    write_reg(ldcm_pkg::REG_RESAMPLE_RATIO, s.resample_ratio);
    cfg_we_i <= 1'b0;
    setups_done++;
  endtask

  function automatic logic [31:0] edge_word();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  // Radial coefficient in the range -0.5 .. 0.5.
  function automatic logic [31:0] coeff_word();
    return 32'($urandom_range(0, 32'h0FFF_FFFF)) - 32'h0800_0000;
  endfunction

  function automatic lens_setup_t draw_setup(setup_kind_e kind);
    lens_setup_t s;
    logic [31:0] term;
    s.inverse_focal   = {32'($urandom_range(8389, 83886)), 32'($urandom_range(8389, 83886))};
    s.principal_point = {32'($urandom_range(0, 32'h0800_0000)),
                         32'($urandom_range(0, 32'h0800_0000))};
    s.radial          = {coeff_word(), coeff_word()};
    s.tangential      = {32'($urandom_range(0, 32'h003F_FFFF)) - 32'h0020_0000,
                         32'($urandom_range(0, 32'h003F_FFFF)) - 32'h0020_0000};
    s.src_focal       = {32'($urandom_range(32'h00C8_0000, 32'h07D0_0000)),
                         32'($urandom_range(32'h00C8_0000, 32'h07D0_0000))};
    s.src_center      = {32'($urandom_range(0, 32'h0800_0000)),
                         32'($urandom_range(0, 32'h0800_0000))};
    s.resample_ratio  = {32'($urandom_range(32'h0040_0000, 32'h0400_0000)),
                         32'($urandom_range(32'h0040_0000, 32'h0400_0000))};
    case (kind)
      SETUP_RESCALE: begin
        s.radial     = '0;
        s.tangential = '0;
      end
      SETUP_ONE_TERM: begin
        term         = coeff_word() | 32'h1;
        s.radial     = '0;
        s.tangential = '0;
        case ($urandom_range(0, 3))
          0:       s.radial[31:0]      = term;
          1:       s.radial[63:32]     = term;
          2:       s.tangential[31:0]  = term;
          default: s.tangential[63:32] = term;
        endcase
      end
      SETUP_WILD: begin
        for (int w = 0; w < 14; w++) s[w*32 +: 32] = $urandom;
      end
      SETUP_EXTREME: begin
        for (int w = 0; w < 14; w++) s[w*32 +: 32] = edge_word();
      end
      default: ;
    endcase
    return s;
  endfunction

  // Mostly coordinates of a real sensor, with full-range and corner values mixed in.
  function automatic logic [15:0] draw_coord();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return 16'($urandom_range(0, 4095));
    if (roll < 9) return 16'($urandom);
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      default: return 16'h7FFF;
    endcase
  endfunction

  initial begin
    lens_setup_t setup;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_idle(IDLE_NONE);

    // Registers at reset: rescale with a zero ratio, so every result is -0.5.
    send_pixel(16'd0, 16'd0);
    send_pixel(16'hFFFF, 16'hFFFF);

    // Largest ratio: the rescale saturates at the far corners.
    setup = '0;
    setup.resample_ratio = '1;
    apply_setup(setup);
    send_pixel(16'd0, 16'd0);
    send_pixel(16'hFFFF, 16'd0);
    send_pixel(16'd0, 16'hFFFF);
    send_pixel(16'hFFFF, 16'hFFFF);

    setup.resample_ratio = {32'h0200_0000, 32'h0100_0000};
    apply_setup(setup);
    send_pixel(16'd1, 16'd2);
    send_pixel(16'd640, 16'd480);

    s_axis_tvalid <= 1'b0;
    settle();
    write_reg(REG_BEYOND_LAST, '1);
    cfg_we_i <= 1'b0;
    send_pixel(16'd640, 16'd480);

    // A plausible VGA lens: f = 500, centre (320, 240), mild barrel distortion.
    setup.inverse_focal   = {32'h0000_8312, 32'h0000_8312};
    setup.principal_point = {32'h00F0_0000, 32'h0140_0000};
    setup.radial          = {32'h00CC_CCCD, 32'hFCCC_CCCD};
    setup.tangential      = {32'hFFFB_E76D, 32'h0004_1893};
    setup.src_focal       = {32'h01F4_0000, 32'h01F4_0000};
    setup.src_center      = {32'h00F0_0000, 32'h0140_0000};
    setup.resample_ratio  = {32'h0100_0000, 32'h0100_0000};
    apply_setup(setup);
    send_pixel(16'd0, 16'd0);
    send_pixel(16'd320, 16'd240);
    send_pixel(16'd639, 16'd479);
    send_pixel(16'hFFFF, 16'hFFFF);

    // Zero reciprocals with live coefficients: the normalised point collapses to zero.
    setup.inverse_focal = '0;
    apply_setup(setup);
    send_pixel(16'd100, 16'd200);
    send_pixel(16'hFFFF, 16'd0);

    setup = '1;
    apply_setup(setup);
    send_pixel(16'd0, 16'd0);
    send_pixel(16'hFFFF, 16'hFFFF);

    setup.radial     = {32'h8000_0000, 32'h7FFF_FFFF};
    setup.tangential = {32'h7FFF_FFFF, 32'h8000_0000};
    apply_setup(setup);
    send_pixel(16'd0, 16'hFFFF);
    send_pixel(16'hFFFF, 16'd0);
    send_pixel(16'd12345, 16'd54321);

    for (int phase = 0; phase < PHASES; phase++) begin
      apply_setup(draw_setup(setup_kind_e'(phase % 5)));
      set_idle(idle_mode_e'(phase % 4));
      // Long output hold-off while the input keeps offering beats back to back.
      if (phase == 0) hold_cycles = HOLD_OFF;
      for (int n = 0; n < PHASE_BEATS; n++) send_pixel(draw_coord(), draw_coord());
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (ldcm_pkg::STAGES + 10) @(posedge clk_i);

    $display("Sent %0d pixel beats under %0d register setups and checked %0d source beats.",
             pixels_sent, setups_done, checked);
    $display("Setups: rescale, lens, single term, random and extreme words; all idle patterns.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
